// ===== rtl/core/afk_pkg.sv =====
// shared constants, types and helper functions of the arm forward kinematics block
`timescale 1ns / 1ps
package afk_pkg;

    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    localparam int ROT_W   = 16;
    localparam int GRIP_W  = 17;
    localparam int LEN_W   = 15;
    localparam int JOINT_W = 16;
    localparam int POS_W   = 19;
    localparam int XY_W    = 34;
    localparam int WIDE_W  = 48;

    localparam logic signed [ROT_W-1:0] ONE_Q14  = 16'sd16384;
    localparam logic signed [POS_W-1:0] GRIP_MAX = 19'sd65535;
    localparam logic signed [POS_W-1:0] GRIP_MIN = -19'sd65536;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    localparam logic [LEN_W-1:0]          RST_UPPER  = 15'd10014;
    localparam logic [LEN_W-1:0]          RST_FORE   = 15'd9326;
    localparam logic [LEN_W-1:0]          RST_TOOL   = 15'd8002;
    localparam logic signed [JOINT_W-1:0] RST_OFFSET = 16'sd10237;

    localparam longint ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516, 64'sd16775851, 64'sd8388437, 64'sd4194283, 64'sd2097149,
        64'sd1048576, 64'sd524288, 64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768,
        64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048, 64'sd1024, 64'sd512, 64'sd256,
        64'sd128
    };

    typedef enum logic [1:0] {
        REG_UPPER  = 2'd0,
        REG_FORE   = 2'd1,
        REG_TOOL   = 2'd2,
        REG_OFFSET = 2'd3
    } cfg_reg_t;

    typedef logic signed [ROT_W-1:0] rmat_t [0:2][0:2];
    typedef logic signed [POS_W-1:0] pvec_t [0:2];
    typedef logic signed [ROT_W-1:0] jvec_t [0:4];

    // fraction bits of the internal angle format
    function automatic int angle_frac(input int aw);
        int af;
        af = aw - 3;
        if (af < 9)
        begin
            af = 9;
        end
        if (af > 21)
        begin
            af = 21;
        end
        return af;
    endfunction

    // round a positive q30 constant half up to fewer fraction bits
    function automatic longint rnd_const(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint atan_of(input int i, input int af);
        return rnd_const(ATAN_Q30[i], 30 - af);
    endfunction

    // round half up with floor shift
    function automatic logic signed [WIDE_W-1:0] rnd_shift(
        input logic signed [WIDE_W-1:0] v,
        input int n
    );
        return (v + (48'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [ROT_W-1:0] rnd_sat_rot(
        input logic signed [WIDE_W-1:0] v,
        input int n
    );
        logic signed [WIDE_W-1:0] t;
        t = rnd_shift(v, n);
        if (t > 48'sd16384)
        begin
            return ONE_Q14;
        end
        if (t < -48'sd16384)
        begin
            return -ONE_Q14;
        end
        return ROT_W'(t);
    endfunction

    // child rotation of each chained link
    function automatic rmat_t cmat(
        input int joint,
        input logic signed [ROT_W-1:0] c,
        input logic signed [ROT_W-1:0] s
    );
        rmat_t m;
        m = '{default: '{default: '0}};
        m[0][0] = c;
        m[0][1] = -s;
        unique case (joint)
            1:
            begin
                m[1][2] = ONE_Q14;
                m[2][0] = -s;
                m[2][1] = -c;
            end
            2:
            begin
                m[1][0] = -s;
                m[1][1] = -c;
                m[2][2] = -ONE_Q14;
            end
            3:
            begin
                m[1][0] = s;
                m[1][1] = c;
                m[2][2] = ONE_Q14;
            end
            default:
            begin
                m[1][2] = -ONE_Q14;
                m[2][0] = s;
                m[2][1] = c;
            end
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/afk_sincos.sv =====
// one joint lane: angle reduction, pipelined cordic and output rounding
`timescale 1ns / 1ps
module afk_sincos #(
    parameter int AF  = 13,
    parameter int NCS = 16,
    parameter int ZW  = 18,
    parameter int NL  = 19
) (
    input  logic                              clk,
    input  logic [NL-1:0]                     en,
    input  logic signed [ZW-1:0]              z_in,
    output logic signed [afk_pkg::ROT_W-1:0]  c,
    output logic signed [afk_pkg::ROT_W-1:0]  s
);

    localparam int XW = afk_pkg::XY_W;
    localparam logic signed [ZW-1:0] PI_Z =
        ZW'(afk_pkg::rnd_const(afk_pkg::PI_Q30, 30 - AF));
    localparam logic signed [ZW-1:0] HP_Z =
        ZW'(afk_pkg::rnd_const(afk_pkg::HALF_PI_Q30, 30 - AF));
    localparam logic signed [XW-1:0] GAIN_X = XW'(afk_pkg::GAIN_Q30);

    logic signed [ZW-1:0] z1_next, z1_reg, z2_next, z2_reg;
    logic                 f1_next, f1_reg, f2_next, f2_reg;

    logic signed [XW-1:0] xr_reg [0:NCS-1];
    logic signed [XW-1:0] yr_reg [0:NCS-1];
    logic signed [ZW-1:0] zr_reg [0:NCS-1];
    logic                 fr_reg [0:NCS-1];

    logic signed [XW-1:0] xf, yf;
    logic signed [afk_pkg::ROT_W-1:0] c_reg, s_reg;

    // fold down by pi
    always_comb
    begin
        z1_next = z_in;
        f1_next = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (z1_next > HP_Z)
            begin
                z1_next = z1_next - PI_Z;
                f1_next = ~f1_next;
            end
        end
    end

    // fold up by pi
    always_comb
    begin
        z2_next = z1_reg;
        f2_next = f1_reg;
        for (int k = 0; k < 4; k++)
        begin
            if (z2_next < -HP_Z)
            begin
                z2_next = z2_next + PI_Z;
                f2_next = ~f2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z1_reg <= z1_next;
            f1_reg <= f1_next;
        end
        if (en[1])
        begin
            z2_reg <= z2_next;
            f2_reg <= f2_next;
        end
    end

    for (genvar i = 0; i < NCS; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] STEP = ZW'(afk_pkg::atan_of(i, AF));
        logic signed [XW-1:0] xa, ya;
        logic signed [ZW-1:0] za;
        logic                 fa;

        if (i == 0)
        begin : g_first
            assign xa = GAIN_X;
            assign ya = '0;
            assign za = z2_reg;
            assign fa = f2_reg;
        end
        else
        begin : g_next
            assign xa = xr_reg[i-1];
            assign ya = yr_reg[i-1];
            assign za = zr_reg[i-1];
            assign fa = fr_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[2+i])
            begin
                if (!za[ZW-1])
                begin
                    xr_reg[i] <= xa - (ya >>> i);
                    yr_reg[i] <= ya + (xa >>> i);
                    zr_reg[i] <= za - STEP;
                end
                else
                begin
                    xr_reg[i] <= xa + (ya >>> i);
                    yr_reg[i] <= ya - (xa >>> i);
                    zr_reg[i] <= za + STEP;
                end
                fr_reg[i] <= fa;
            end
        end
    end

    // undo the folds, round to q1.14
    assign xf = fr_reg[NCS-1] ? -xr_reg[NCS-1] : xr_reg[NCS-1];
    assign yf = fr_reg[NCS-1] ? -yr_reg[NCS-1] : yr_reg[NCS-1];

    always_ff @(posedge clk)
    begin
        if (en[NL-1])
        begin
            c_reg <= afk_pkg::rnd_sat_rot(afk_pkg::WIDE_W'(xf), 16);
            s_reg <= afk_pkg::rnd_sat_rot(afk_pkg::WIDE_W'(yf), 16);
        end
    end

    assign c = c_reg;
    assign s = s_reg;

endmodule

// ===== rtl/core/afk_chain.sv =====
// one link of the transform chain: products, then sums with rounding
`timescale 1ns / 1ps
module afk_chain #(
    parameter int JOINT = 1
) (
    input  logic                              clk,
    input  logic [1:0]                        en,
    input  afk_pkg::rmat_t                    r_in,
    input  afk_pkg::pvec_t                    p_in,
    input  logic signed [afk_pkg::ROT_W-1:0]  c,
    input  logic signed [afk_pkg::ROT_W-1:0]  s,
    input  logic [afk_pkg::LEN_W-1:0]         tx,
    output afk_pkg::rmat_t                    r_out,
    output afk_pkg::pvec_t                    p_out
);

    afk_pkg::rmat_t cm;
    logic signed [afk_pkg::ROT_W-1:0] txs;
    logic signed [31:0] pr_reg [0:2][0:2][0:2];
    logic signed [31:0] ptx_reg [0:2];
    afk_pkg::pvec_t p_a_reg;
    afk_pkg::rmat_t r_reg;
    afk_pkg::pvec_t p_reg;
    logic signed [33:0] sum [0:2][0:2];

    assign cm  = afk_pkg::cmat(JOINT, c, s);
    assign txs = $signed({1'b0, tx});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pr_reg[i][j][k] <= r_in[i][k] * cm[k][j];
                    end
                end
                ptx_reg[i] <= r_in[i][0] * txs;
                p_a_reg[i] <= p_in[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum[i][j] = 34'(pr_reg[i][j][0]) + 34'(pr_reg[i][j][1])
                          + 34'(pr_reg[i][j][2]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r_reg[i][j] <= afk_pkg::rnd_sat_rot(afk_pkg::WIDE_W'(sum[i][j]), 14);
                end
                p_reg[i] <= p_a_reg[i] + afk_pkg::POS_W'(
                    afk_pkg::rnd_shift(afk_pkg::WIDE_W'(ptx_reg[i]), 14));
            end
        end
    end

    assign r_out = r_reg;
    assign p_out = p_reg;

endmodule

// ===== rtl/core/arm_forward_kinematics.sv =====
// top level of the five-joint arm forward kinematics pipeline
//
//  channel | direction | handshake            | contents
//  --------+-----------+----------------------+------------------------------------
//  in      | to block  | in_valid / in_stall  | joint_one .. joint_five, q3.13 rad
//  out     | from blk  | out_valid / out_stall| rot_xx .. rot_zz, grip_x .. grip_z
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one transaction per cycle in each direction, on in and out only while not stalled;
// one register stage per cordic iteration plus the input scaling, the angle folding,
// the output rounding, the four two-stage link products and the gripper stages
// reset clears the stage valid bits and loads the register defaults
// a stall on the output freezes only the run of full stages behind the output,
// so bubbles close up and input keeps flowing until the pipeline is full
`timescale 1ns / 1ps
module arm_forward_kinematics #(
    parameter int ANGLE_WIDTH   = afk_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = afk_pkg::CORDIC_STAGES_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [afk_pkg::JOINT_W-1:0]  joint_one,
    input  logic signed [afk_pkg::JOINT_W-1:0]  joint_two,
    input  logic signed [afk_pkg::JOINT_W-1:0]  joint_three,
    input  logic signed [afk_pkg::JOINT_W-1:0]  joint_four,
    input  logic signed [afk_pkg::JOINT_W-1:0]  joint_five,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_xx,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_xy,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_xz,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_yx,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_yy,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_yz,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_zx,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_zy,
    output logic signed [afk_pkg::ROT_W-1:0]    rot_zz,
    output logic signed [afk_pkg::GRIP_W-1:0]   grip_x,
    output logic signed [afk_pkg::GRIP_W-1:0]   grip_y,
    output logic signed [afk_pkg::GRIP_W-1:0]   grip_z,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [15:0]                         cfg_data
);

    // angle format and stage map
    localparam int AF  = afk_pkg::angle_frac(ANGLE_WIDTH);
    localparam int NCS = (CORDIC_STAGES > afk_pkg::ATAN_ENTRIES) ?
                         afk_pkg::ATAN_ENTRIES : CORDIC_STAGES;
    localparam int ZW  = AF + 5;
    localparam int NL  = NCS + 3;       // stages inside one joint lane
    localparam int NS  = NL + 11;       // prep + lanes + 4 links x 2 + gripper x 2
    localparam logic signed [ZW-1:0] HP_Z =
        ZW'(afk_pkg::rnd_const(afk_pkg::HALF_PI_Q30, 30 - AF));

    // configuration registers
    logic [afk_pkg::LEN_W-1:0]          upper_reg, fore_reg, tool_reg;
    logic signed [afk_pkg::JOINT_W-1:0] offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= afk_pkg::RST_UPPER;
            fore_reg   <= afk_pkg::RST_FORE;
            tool_reg   <= afk_pkg::RST_TOOL;
            offset_reg <= afk_pkg::RST_OFFSET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (afk_pkg::cfg_reg_t'(cfg_index))
                afk_pkg::REG_UPPER:  upper_reg  <= cfg_data[afk_pkg::LEN_W-1:0];
                afk_pkg::REG_FORE:   fore_reg   <= cfg_data[afk_pkg::LEN_W-1:0];
                afk_pkg::REG_TOOL:   tool_reg   <= cfg_data[afk_pkg::LEN_W-1:0];
                afk_pkg::REG_OFFSET: offset_reg <= $signed(cfg_data);
            endcase
        end
    end

    // stage valid bits and per-stage advance; a stage loads when it is empty
    // or when the stage after it loads too
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   en;

    assign en[NS] = ~out_stall;
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = ~vld_reg[k] | en[k+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = ~en[0];
    assign out_valid = vld_reg[NS-1];

    // stage 0: scale to the internal angle format, apply joint offsets
    logic signed [afk_pkg::JOINT_W-1:0] jin [0:5];
    logic signed [ZW-1:0] qs [0:5];
    logic signed [ZW-1:0] z0_next [0:4];
    logic signed [ZW-1:0] z0_reg  [0:4];

    assign jin[0] = joint_one;
    assign jin[1] = joint_two;
    assign jin[2] = joint_three;
    assign jin[3] = joint_four;
    assign jin[4] = joint_five;
    assign jin[5] = offset_reg;

    for (genvar j = 0; j < 6; j++)
    begin : g_scale
        if (AF >= 13)
        begin : g_up
            assign qs[j] = ZW'(jin[j]) <<< (AF - 13);
        end
        else
        begin : g_down
            logic signed [17:0] t;
            assign t     = (18'(jin[j]) + (18'sd1 <<< (12 - AF))) >>> (13 - AF);
            assign qs[j] = ZW'(t);
        end
    end

    assign z0_next[0] = qs[0];
    assign z0_next[1] = qs[1] - qs[5];
    assign z0_next[2] = qs[2] - qs[5];
    assign z0_next[3] = qs[3] + HP_Z;
    assign z0_next[4] = qs[4];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 5; j++)
            begin
                z0_reg[j] <= z0_next[j];
            end
        end
    end

    // stages 1..NL: one sine/cosine lane per joint
    afk_pkg::jvec_t c_lane, s_lane;

    for (genvar j = 0; j < 5; j++)
    begin : g_lane
        afk_sincos #(
            .AF  (AF),
            .NCS (NCS),
            .ZW  (ZW),
            .NL  (NL)
        ) u_sincos (
            .clk  (clk),
            .en   (en[NL:1]),
            .z_in (z0_reg[j]),
            .c    (c_lane[j]),
            .s    (s_lane[j])
        );
    end

    // sine and cosine travel alongside the link stages until their link uses them
    afk_pkg::jvec_t cd_reg [1:6];
    afk_pkg::jvec_t sd_reg [1:6];

    always_ff @(posedge clk)
    begin
        if (en[NL+1])
        begin
            cd_reg[1] <= c_lane;
            sd_reg[1] <= s_lane;
        end
    end

    for (genvar m = 2; m <= 6; m++)
    begin : g_delay
        always_ff @(posedge clk)
        begin
            if (en[NL+m])
            begin
                cd_reg[m] <= cd_reg[m-1];
                sd_reg[m] <= sd_reg[m-1];
            end
        end
    end

    // base rotation and the link chain
    afk_pkg::rmat_t rch [0:4];
    afk_pkg::pvec_t pch [0:4];

    assign rch[0] = '{
        '{c_lane[0], -s_lane[0], '0},
        '{s_lane[0], c_lane[0], '0},
        '{'0, '0, afk_pkg::ONE_Q14}
    };
    assign pch[0] = '{default: '0};

    for (genvar k = 1; k <= 4; k++)
    begin : g_chain
        logic signed [afk_pkg::ROT_W-1:0] cj, sj;
        logic [afk_pkg::LEN_W-1:0]        txj;

        if (k == 1)
        begin : g_k1
            assign cj  = c_lane[1];
            assign sj  = s_lane[1];
            assign txj = '0;
        end
        else if (k == 2)
        begin : g_k2
            assign cj  = cd_reg[2][2];
            assign sj  = sd_reg[2][2];
            assign txj = upper_reg;
        end
        else if (k == 3)
        begin : g_k3
            assign cj  = cd_reg[4][3];
            assign sj  = sd_reg[4][3];
            assign txj = fore_reg;
        end
        else
        begin : g_k4
            assign cj  = cd_reg[6][4];
            assign sj  = sd_reg[6][4];
            assign txj = '0;
        end

        afk_chain #(
            .JOINT (k)
        ) u_chain (
            .clk   (clk),
            .en    (en[NL+2*k:NL+2*k-1]),
            .r_in  (rch[k-1]),
            .p_in  (pch[k-1]),
            .c     (cj),
            .s     (sj),
            .tx    (txj),
            .r_out (rch[k]),
            .p_out (pch[k])
        );
    end

    // gripper point: tool length along the approach column, then saturate
    logic signed [31:0]          gp_reg [0:2];
    afk_pkg::rmat_t              rg_reg, ro_reg;
    afk_pkg::pvec_t              pg_reg;
    logic signed [afk_pkg::ROT_W-1:0]  tool_s;
    logic signed [afk_pkg::POS_W-1:0]  g_sum [0:2];
    logic signed [afk_pkg::GRIP_W-1:0] grip_reg [0:2];

    assign tool_s = $signed({1'b0, tool_reg});

    always_ff @(posedge clk)
    begin
        if (en[NL+9])
        begin
            for (int i = 0; i < 3; i++)
            begin
                gp_reg[i] <= rch[4][i][2] * tool_s;
            end
            rg_reg <= rch[4];
            pg_reg <= pch[4];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g_sum[i] = pg_reg[i] + afk_pkg::POS_W'(
                afk_pkg::rnd_shift(afk_pkg::WIDE_W'(gp_reg[i]), 14));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NL+10])
        begin
            ro_reg <= rg_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (g_sum[i] > afk_pkg::GRIP_MAX)
                begin
                    grip_reg[i] <= afk_pkg::GRIP_W'(afk_pkg::GRIP_MAX);
                end
                else if (g_sum[i] < afk_pkg::GRIP_MIN)
                begin
                    grip_reg[i] <= afk_pkg::GRIP_W'(afk_pkg::GRIP_MIN);
                end
                else
                begin
                    grip_reg[i] <= afk_pkg::GRIP_W'(g_sum[i]);
                end
            end
        end
    end

    assign rot_xx = ro_reg[0][0];
    assign rot_xy = ro_reg[0][1];
    assign rot_xz = ro_reg[0][2];
    assign rot_yx = ro_reg[1][0];
    assign rot_yy = ro_reg[1][1];
    assign rot_yz = ro_reg[1][2];
    assign rot_zx = ro_reg[2][0];
    assign rot_zy = ro_reg[2][1];
    assign rot_zz = ro_reg[2][2];
    assign grip_x = grip_reg[0];
    assign grip_y = grip_reg[1];
    assign grip_z = grip_reg[2];

endmodule

// ===== rtl/core/afk_checker.sv =====
// port-level checks of the arm forward kinematics block, bound to the top level
`timescale 1ns / 1ps
module afk_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic signed [afk_pkg::ROT_W-1:0]   rot_xx,
    input logic signed [afk_pkg::ROT_W-1:0]   rot_zz,
    input logic signed [afk_pkg::GRIP_W-1:0]  grip_x,
    input logic signed [afk_pkg::GRIP_W-1:0]  grip_z
);

    // an empty output stage never holds back the input
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage empty");

    // a free output lets the whole pipeline move
    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !out_stall) |-> !in_stall)
        else $error("input stalled while output not stalled");

    // the rot_xx and rot_zz entries stay inside the unit range
    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rot_xx >= -16'sd16384 && rot_xx <= 16'sd16384
                       && rot_zz >= -16'sd16384 && rot_zz <= 16'sd16384))
        else $error("rotation entry out of range");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(rot_xx)
                                      && $stable(grip_x) && $stable(grip_z)))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind arm_forward_kinematics afk_checker u_afk_checker (.*);
